// ----- rtl/core/flsc_pkg.sv -----
package flsc_pkg;

    localparam int PATTERN_MAX_DEF = 16;
    localparam int COUNT_BITS_DEF  = 16;

    localparam int ADDR_BITS     = 5;
    localparam int DATA_BITS     = 64;
    localparam int PAT_SLOTS     = 16;
    localparam int PAT_IDX_BITS  = 4;
    localparam int PAT_LEN_BITS  = 5;
    localparam int OUT_CNT_BITS  = 16;
    localparam int OUT_DATA_BITS = 24;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

    typedef enum logic [1:0] {
        REG_PAT_LO  = 2'd0,
        REG_PAT_HI  = 2'd1,
        REG_PAT_LEN = 2'd2
    } t_reg_idx;

endpackage

// ----- rtl/core/folded_line_substring_counter.sv -----
// Folded line substring counter.
// Slave stream: one text byte per word in s_tdata[7:0]; s_tlast marks a line end,
// and the data bits of that word are ignored. Letters are folded to lower case,
// all other bytes are dropped, and the last letters of the line are compared in
// parallel against the pattern held in the APB registers (low and high letters at
// 0x00 and 0x08, 64-bit; length at 0x10, 5 bits). Length zero matches every line.
// Master stream: one word per line end, m_tdata[0] = line matched,
// m_tdata[16:1] = running count of matching lines (saturating).
// Throughput: one word per cycle on the slave side while the master side keeps up;
// the input register and the result register are both fully pipelined, the window
// update and compare sit between them.
// When the master side stalls, the result register holds; the input register
// keeps taking text bytes, and a line end waits in the input register, with
// s_tready low, until the result register frees.
// Reset (synchronous, active low) clears the registers, the count, the letter
// count and the hit flag, and empties both pipeline registers.
// Program the pattern only while the streams are idle.
module folded_line_substring_counter #(
    parameter int PATTERN_MAX = flsc_pkg::PATTERN_MAX_DEF,
    parameter int COUNT_BITS  = flsc_pkg::COUNT_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [flsc_pkg::ADDR_BITS-1:0]    paddr,
    input  logic [flsc_pkg::DATA_BITS-1:0]    pwdata,
    output logic [flsc_pkg::DATA_BITS-1:0]    prdata,
    output logic                              pready,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [7:0]                        i_s_tdata,  // [7:0] text_byte
    input  logic                              i_s_tlast,  // is_line_end
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [flsc_pkg::OUT_DATA_BITS-1:0] o_m_tdata  // [0] line_matched,
                                                          // [16:1] matching_lines
);
    import flsc_pkg::*;

    localparam int LEN_BITS = $clog2(PATTERN_MAX + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [DATA_BITS-1:0]    r_pat_lo;
    logic [DATA_BITS-1:0]    r_pat_hi;
    logic [PAT_LEN_BITS-1:0] r_pat_len;

    logic [7:0]          r_aligned [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] r_pos_en;
    logic [LEN_BITS-1:0] r_used_len;

    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_in_last;

    logic [7:0]          r_window [PATTERN_MAX];
    logic [LEN_BITS-1:0] r_letters;
    logic                r_hit;
    logic [COUNT_BITS-1:0] r_count;

    logic                r_out_valid;
    logic                r_out_matched;

    logic [7:0]          n_aligned [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] n_pos_en;
    logic [LEN_BITS-1:0] n_used_len;
    logic [7:0]          pat_bytes [PAT_SLOTS];
    logic [LEN_BITS-1:0] diff;

    logic                cfg_wr;
    logic                out_free;
    logic                advance;
    logic                do_end;
    logic                do_letter;
    logic                is_upper;
    logic                is_lower;
    logic [7:0]          folded;
    logic [7:0]          n_window [PATTERN_MAX];
    logic [LEN_BITS-1:0] n_letters;
    logic                win_eq;
    logic                line_matched;
    logic                n_hit;
    logic [COUNT_BITS-1:0] n_count;
    logic [COUNT_BITS+OUT_CNT_BITS-1:0] count_ext;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_pat_len <= '0;
        end else if (cfg_wr) begin
            unique case (t_reg_idx'(paddr[4:3]))
                REG_PAT_LO:  r_pat_lo  <= pwdata;
                REG_PAT_HI:  r_pat_hi  <= pwdata;
                REG_PAT_LEN: r_pat_len <= pwdata[PAT_LEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[4:3]))
            REG_PAT_LO:  prdata = r_pat_lo;
            REG_PAT_HI:  prdata = r_pat_hi;
            REG_PAT_LEN: prdata = {{(DATA_BITS-PAT_LEN_BITS){1'b0}}, r_pat_len};
            default:     prdata = '0;
        endcase
    end

    // Align the pattern to window positions: position j holds letter len-1-j
    always_comb begin
        for (int k = 0; k < PAT_SLOTS / 2; k++) begin
            pat_bytes[k]                 = r_pat_lo[k*8 +: 8];
            pat_bytes[k + PAT_SLOTS / 2] = r_pat_hi[k*8 +: 8];
        end
        if (r_pat_len > PAT_LEN_BITS'(PATTERN_MAX)) begin
            n_used_len = LEN_BITS'(PATTERN_MAX);
        end else begin
            n_used_len = LEN_BITS'(r_pat_len);
        end
        diff = '0;
        for (int j = 0; j < PATTERN_MAX; j++) begin
            diff        = LEN_BITS'(n_used_len - LEN_BITS'(1) - LEN_BITS'(j));
            n_pos_en[j] = LEN_BITS'(j) < n_used_len;
            n_aligned[j] = pat_bytes[PAT_IDX_BITS'(diff)];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos_en   <= n_pos_en;
        r_used_len <= n_used_len;
        for (int j = 0; j < PATTERN_MAX; j++) begin
            r_aligned[j] <= n_aligned[j];
        end
    end

    // Input register
    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && (!r_in_last || out_free);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    // Filter, shift and compare
    assign is_upper  = (r_in_byte >= CHAR_UPPER_A) && (r_in_byte <= CHAR_UPPER_Z);
    assign is_lower  = (r_in_byte >= CHAR_LOWER_A) && (r_in_byte <= CHAR_LOWER_Z);
    assign folded    = is_upper ? 8'(r_in_byte + (CHAR_LOWER_A - CHAR_UPPER_A)) : r_in_byte;
    assign do_end    = advance && r_in_last;
    assign do_letter = advance && !r_in_last && (is_upper || is_lower);

    always_comb begin
        n_window[0] = folded;
        for (int j = 1; j < PATTERN_MAX; j++) begin
            n_window[j] = r_window[j-1];
        end
        if (r_letters < LEN_BITS'(PATTERN_MAX)) begin
            n_letters = LEN_BITS'(r_letters + LEN_BITS'(1));
        end else begin
            n_letters = r_letters;
        end
        win_eq = 1'b1;
        for (int j = 0; j < PATTERN_MAX; j++) begin
            if (r_pos_en[j] && (n_window[j] != r_aligned[j])) begin
                win_eq = 1'b0;
            end
        end
        n_hit = r_hit || (r_used_len == '0) || (win_eq && (n_letters >= r_used_len));
    end

    assign line_matched = r_hit || (r_used_len == '0);
    assign n_count = (line_matched && (r_count != COUNT_MAX))
                   ? COUNT_BITS'(r_count + COUNT_BITS'(1)) : r_count;

    always_ff @(posedge i_clk) begin
        if (do_letter) begin
            for (int j = 0; j < PATTERN_MAX; j++) begin
                r_window[j] <= n_window[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_letters <= '0;
            r_hit     <= 1'b0;
            r_count   <= '0;
        end else if (do_end) begin
            r_letters <= '0;
            r_hit     <= 1'b0;
            r_count   <= n_count;
        end else if (do_letter) begin
            r_letters <= n_letters;
            r_hit     <= n_hit;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= do_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_end) begin
            r_out_matched <= line_matched;
        end
    end

    assign count_ext  = {{OUT_CNT_BITS{1'b0}}, r_count};
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_BITS-OUT_CNT_BITS-1){1'b0}},
                         count_ext[OUT_CNT_BITS-1:0], r_out_matched};

    a_letters_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_letters <= LEN_BITS'(PATTERN_MAX))
        else $error("letter count above window depth");

    a_hit_needs_letters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_letter && !r_hit && n_hit && (r_used_len != '0) |-> n_letters >= r_used_len)
        else $error("hit flagged before the window was full");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_count != $past(r_count))
        |-> (r_count == COUNT_BITS'($past(r_count) + COUNT_BITS'(1))) && $past(do_end))
        else $error("match count moved without a line end");

    a_result_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_end |=> r_out_valid && (r_out_matched == $past(line_matched)))
        else $error("line end did not load the result register");

endmodule
